// ===== rtl/core/twpt_pkg.sv =====
package twpt_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int WAIT_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_HOLD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_HOLD  = 2'd3;

    localparam logic [7:0]  SETUP_RESET      = 8'd5;
    localparam logic [9:0]  HALF_RESET       = 10'd50;
    localparam logic [15:0] START_HOLD_RESET = 16'd1000;
    localparam logic [15:0] STOP_HOLD_RESET  = 16'd10000;

    typedef struct packed {
        logic [7:0]  setup_ticks;
        logic [9:0]  half_period_ticks;
        logic [15:0] start_hold_ticks;
        logic [15:0] stop_hold_ticks;
    } cfg_t;

    // Classified request: a send carries the packet bytes, byte 0 in the low bits.
    typedef struct packed {
        logic        is_send;
        logic [31:0] bytes;
    } req_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic packet_done;
        logic rejected;
    } res_t;

    typedef enum logic [3:0] {
        STEP_START_CLK_LOW   = 4'd0,
        STEP_START_DATA_LOW  = 4'd1,
        STEP_START_CLK_REL   = 4'd2,
        STEP_START_DATA_HIGH = 4'd3,
        STEP_BIT_DATA        = 4'd4,
        STEP_BIT_CLK_LOW     = 4'd5,
        STEP_BIT_CLK_REL     = 4'd6,
        STEP_STOP_DATA_LOW   = 4'd7,
        STEP_STOP_CLK_LOW    = 4'd8,
        STEP_STOP_DATA_HIGH  = 4'd9,
        STEP_STOP_CLK_REL    = 4'd10
    } step_t;

endpackage

// ===== rtl/core/twpt_front.sv =====
module twpt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_counter_byte,
    input  logic [7:0]         s_target_byte,
    input  logic [7:0]         s_command_byte,
    input  logic [7:0]         s_check_byte,
    output logic               req_valid,
    input  logic               req_ready,
    output twpt_pkg::req_t     req
);
    import twpt_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign s_ready   = !valid_reg || req_ready;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Classify on capture: ticks carry no bytes.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg.is_send <= s_kind;
            req_reg.bytes   <= s_kind ? {s_check_byte, s_command_byte,
                                         s_target_byte, s_counter_byte} : 32'd0;
        end
    end

endmodule

// ===== rtl/core/twpt_queue.sv =====
module twpt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  twpt_pkg::req_t     push_req,
    output logic               pop_valid,
    input  logic               pop_ready,
    output twpt_pkg::req_t     pop_req
);
    import twpt_pkg::*;

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/core/twpt_back.sv =====
module twpt_back #(
    parameter int PACKET_BYTES  = 4,
    parameter int BITS_PER_BYTE = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  twpt_pkg::cfg_t     cfg,
    input  logic               req_valid,
    output logic               req_ready,
    input  twpt_pkg::req_t     req,
    output logic               res_valid,
    input  logic               res_ready,
    output twpt_pkg::res_t     res
);
    import twpt_pkg::*;

    localparam int TOTAL_BITS = PACKET_BYTES * BITS_PER_BYTE;
    localparam int SHIFT_W    = TOTAL_BITS;
    localparam int BIT_W      = $clog2(TOTAL_BITS + 1);
    localparam int LOAD_W     = (SHIFT_W > 32) ? SHIFT_W : 32;

    step_t               step_reg;
    step_t               step_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [WAIT_W-1:0]   wait_next;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [SHIFT_W-1:0]  shift_next;
    logic [BIT_W-1:0]    bit_reg;
    logic [BIT_W-1:0]    bit_next;
    logic [BIT_W-1:0]    bit_inc;
    logic                clock_reg;
    logic                clock_next;
    logic                data_reg;
    logic                data_next;
    logic                active_reg;
    logic                active_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                out_reg;
    res_t                out_next;
    logic                pop;
    logic                do_enter;
    step_t               target;
    logic                done;
    logic                rej;
    logic [LOAD_W-1:0]   load_word;

    function automatic logic [WAIT_W-1:0] wait_of(input logic [WAIT_W-1:0] n);
        wait_of = (n == '0) ? WAIT_W'(1) : n;
    endfunction

    assign req_ready = !out_valid_reg || res_ready;
    assign pop       = req_valid && req_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign load_word = LOAD_W'(req.bytes);
    assign bit_inc   = bit_reg + BIT_W'(1);

    always_comb begin
        step_next   = step_reg;
        wait_next   = wait_reg;
        shift_next  = shift_reg;
        bit_next    = bit_reg;
        clock_next  = clock_reg;
        data_next   = data_reg;
        active_next = active_reg;
        do_enter    = 1'b0;
        target      = STEP_START_CLK_LOW;
        done        = 1'b0;
        rej         = 1'b0;

        if (req.is_send) begin
            if (active_reg) begin
                rej = 1'b1;
            end else begin
                shift_next  = load_word[SHIFT_W-1:0];
                bit_next    = '0;
                active_next = 1'b1;
                do_enter    = 1'b1;
                target      = STEP_START_CLK_LOW;
            end
        end else if (active_reg) begin
            if (wait_reg > WAIT_W'(1)) begin
                wait_next = wait_reg - WAIT_W'(1);
            end else begin
                wait_next = '0;
                case (step_reg)
                    STEP_BIT_CLK_REL: begin
                        bit_next = bit_inc;
                        do_enter = 1'b1;
                        target   = (bit_inc >= BIT_W'(TOTAL_BITS)) ? STEP_STOP_DATA_LOW
                                                                    : STEP_BIT_DATA;
                    end
                    STEP_STOP_CLK_REL: begin
                        active_next = 1'b0;
                        step_next   = STEP_START_CLK_LOW;
                        done        = 1'b1;
                    end
                    default: begin
                        do_enter = 1'b1;
                        target   = step_t'(4'(step_reg) + 4'd1);
                    end
                endcase
            end
        end

        if (do_enter) begin
            step_next = target;
            case (target)
                STEP_START_CLK_LOW: begin
                    clock_next = 1'b0;
                    wait_next  = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_START_DATA_LOW: begin
                    data_next = 1'b0;
                    wait_next = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_START_CLK_REL: begin
                    clock_next = 1'b1;
                    wait_next  = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_START_DATA_HIGH: begin
                    data_next = 1'b1;
                    wait_next = wait_of(cfg.start_hold_ticks);
                end
                STEP_BIT_DATA: begin
                    data_next  = shift_reg[0];
                    shift_next = shift_reg >> 1;
                    wait_next  = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_BIT_CLK_LOW: begin
                    clock_next = 1'b0;
                    wait_next  = wait_of(WAIT_W'(cfg.half_period_ticks));
                end
                STEP_BIT_CLK_REL: begin
                    clock_next = 1'b1;
                    wait_next  = wait_of(WAIT_W'(cfg.half_period_ticks));
                end
                STEP_STOP_DATA_LOW: begin
                    data_next = 1'b0;
                    wait_next = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_STOP_CLK_LOW: begin
                    clock_next = 1'b0;
                    wait_next  = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                STEP_STOP_DATA_HIGH: begin
                    data_next = 1'b1;
                    wait_next = wait_of(WAIT_W'(cfg.setup_ticks));
                end
                default: begin
                    clock_next = 1'b1;
                    step_next  = STEP_STOP_CLK_REL;
                    wait_next  = wait_of(cfg.stop_hold_ticks);
                end
            endcase
        end

        out_next.clock_line  = clock_next;
        out_next.data_line   = data_next;
        out_next.busy_res    = active_next;
        out_next.packet_done = done;
        out_next.rejected    = rej;

        out_valid_next = out_valid_reg;
        if (req_ready) begin
            out_valid_next = req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_START_CLK_LOW;
            wait_reg      <= '0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            clock_reg     <= 1'b1;
            data_reg      <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                step_reg   <= step_next;
                wait_reg   <= wait_next;
                shift_reg  <= shift_next;
                bit_reg    <= bit_next;
                clock_reg  <= clock_next;
                data_reg   <= data_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/two_wire_packet_transmitter_top.sv =====
// Two-wire packet transmitter.
// Input channel (s_valid/s_ready): each request is either a tick (s_kind = 0)
// that advances the phase timers by one, or a send (s_kind = 1) carrying four
// packet bytes, sent counter byte first, each byte LSB first, framed by a
// start and a stop sequence. A send while a packet is in progress is dropped
// and flagged in m_rejected.
// Result channel (m_valid/m_ready): exactly one result per request, in order,
// giving the clock and data line levels after that request, busy, done and
// rejected flags.
// Path: each request passes the input register and the request queue, and its result is then registered.
// Throughput: one request per cycle while m_ready is high; the sequencer updates its full
// state from a single request, so nothing limits the rate below that.
// Stall: when m_ready is low the result register holds, the two-entry request
// queue fills, then the input register, and s_ready drops; up to four
// requests are in flight. Nothing is lost.
// Reset (aresetn low, synchronous): lines report clock released and data low,
// idle, all queues empty, delay registers back to their defaults.
// Configuration (cfg_wr_en/cfg_index/cfg_data) must be written only while idle (not enforced here).
module two_wire_packet_transmitter_top #(
    parameter int PACKET_BYTES  = 4,
    parameter int BITS_PER_BYTE = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [twpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [twpt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [7:0]                           s_counter_byte,
    input  logic [7:0]                           s_target_byte,
    input  logic [7:0]                           s_command_byte,
    input  logic [7:0]                           s_check_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_line,
    output logic                                 m_data_line,
    output logic                                 m_busy_res,
    output logic                                 m_packet_done,
    output logic                                 m_rejected
);
    import twpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic front_valid;
    logic front_ready;
    req_t front_req;
    logic queue_valid;
    logic queue_ready;
    req_t queue_req;
    res_t res;

    // Delay registers: mask each write to its register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SETUP:      cfg_next.setup_ticks       = cfg_data[7:0];
                CFG_HALF:       cfg_next.half_period_ticks = cfg_data[9:0];
                CFG_START_HOLD: cfg_next.start_hold_ticks  = cfg_data;
                CFG_STOP_HOLD:  cfg_next.stop_hold_ticks   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setup_ticks       <= SETUP_RESET;
            cfg_reg.half_period_ticks <= HALF_RESET;
            cfg_reg.start_hold_ticks  <= START_HOLD_RESET;
            cfg_reg.stop_hold_ticks   <= STOP_HOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: capture and classify each request.
    twpt_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_counter_byte (s_counter_byte),
        .s_target_byte  (s_target_byte),
        .s_command_byte (s_command_byte),
        .s_check_byte   (s_check_byte),
        .req_valid      (front_valid),
        .req_ready      (front_ready),
        .req            (front_req)
    );

    // Short queue: lets the front keep accepting while the back is stalled.
    twpt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_req   (front_req),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_req    (queue_req)
    );

    // Back: run the line sequencer, one request per cycle while m_ready is high, into the result register.
    twpt_back #(
        .PACKET_BYTES  (PACKET_BYTES),
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (queue_valid),
        .req_ready (queue_ready),
        .req       (queue_req),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_clock_line  = res.clock_line;
    assign m_data_line   = res.data_line;
    assign m_busy_res    = res.busy_res;
    assign m_packet_done = res.packet_done;
    assign m_rejected    = res.rejected;

    // A finished packet leaves the block idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_done |-> !m_busy_res)
        else $error("packet done while still busy");

    // A send is only dropped while a packet is in progress, which it leaves running.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res)
        else $error("send rejected while idle");

    // Idle always leaves the clock line released.
    a_idle_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_clock_line)
        else $error("clock held low while idle");

endmodule
